[rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CpWidth-1:0] CpMax  = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurLow = 21'h00D800;
  localparam logic [CpWidth-1:0] SurHigh = 21'h00DFFF;

  // Lead byte classes
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } u8d_lead_e;

  // One decoded result as it leaves the decoder
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               error;
    logic               last;
  } u8d_result_t;

  function automatic u8d_lead_e u8d_classify(input logic [ByteWidth-1:0] b);
    u8d_lead_e cls;
    if (b[7] == 1'b0) begin
      cls = LEAD_ASCII;
    end else if (b[7:5] == 3'b110) begin
      cls = LEAD_TWO;
    end else if (b[7:4] == 4'b1110) begin
      cls = LEAD_THREE;
    end else if (b[7:3] == 5'b11110) begin
      cls = LEAD_FOUR;
    end else begin
      cls = LEAD_BAD;
    end
    return cls;
  endfunction

  function automatic logic u8d_cp_bad(input logic [CpWidth-1:0] cp);
    return (cp > CpMax) || ((cp >= SurLow) && (cp <= SurHigh));
  endfunction

endpackage

[rtl/u8d_core.sv]
// ----------------------------------------------------------------------------
// u8d_core
// Sequence state and per-byte decode step.
// ----------------------------------------------------------------------------
module u8d_core
  import u8d_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [ByteWidth-1:0] byte_i,
  input  logic                 eos_i,
  output logic                 emit_o,
  output u8d_result_t          result_o
);

  logic [CpWidth-1:0] partial_q, partial_d;
  logic [1:0]         remain_q, remain_d;
  logic               failed_q, failed_d;

  logic [CpWidth-1:0] shifted;
  logic [1:0]         remain_dec;
  logic [CpWidth-1:0] cp;
  logic               cp_ready;
  logic               raise;
  u8d_lead_e          lead;

  assign lead       = u8d_classify(byte_i);
  assign shifted    = {partial_q[CpWidth-7:0], byte_i[5:0]};
  assign remain_dec = remain_q - 2'd1;

  always_comb begin
    partial_d = partial_q;
    remain_d  = remain_q;
    failed_d  = failed_q;
    cp        = '0;
    cp_ready  = 1'b0;
    raise     = 1'b0;

    if (failed_q) begin
      // Drop bytes until the end of the string
      if (eos_i) begin
        failed_d = 1'b0;
      end
    end else if (remain_q == 2'd0) begin
      unique case (lead)
        LEAD_ASCII: begin
          cp       = {{(CpWidth-ByteWidth){1'b0}}, byte_i};
          cp_ready = 1'b1;
        end
        LEAD_TWO: begin
          partial_d = {{(CpWidth-5){1'b0}}, byte_i[4:0]};
          remain_d  = 2'd1;
          raise     = eos_i;
        end
        LEAD_THREE: begin
          partial_d = {{(CpWidth-4){1'b0}}, byte_i[3:0]};
          remain_d  = 2'd2;
          raise     = eos_i;
        end
        LEAD_FOUR: begin
          partial_d = {{(CpWidth-3){1'b0}}, byte_i[2:0]};
          remain_d  = 2'd3;
          raise     = eos_i;
        end
        default: begin
          raise = 1'b1;
        end
      endcase
    end else if (byte_i[7:6] != 2'b10) begin
      raise = 1'b1;
    end else if (remain_dec != 2'd0) begin
      partial_d = shifted;
      remain_d  = remain_dec;
      raise     = eos_i;
    end else begin
      partial_d = '0;
      remain_d  = 2'd0;
      cp        = shifted;
      cp_ready  = 1'b1;
    end

    if (cp_ready && u8d_cp_bad(cp)) begin
      raise = 1'b1;
    end

    if (raise) begin
      partial_d = '0;
      remain_d  = 2'd0;
      failed_d  = !eos_i;
    end

    emit_o              = raise || cp_ready;
    result_o.code_point = raise ? '0 : cp;
    result_o.error      = raise;
    result_o.last       = raise || eos_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      remain_q  <= 2'd0;
      failed_q  <= 1'b0;
    end else if (step_i) begin
      partial_q <= partial_d;
      remain_q  <= remain_d;
      failed_q  <= failed_d;
    end
  end

endmodule

[rtl/u8d_out_reg.sv]
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result register in front of the output stream.
// ----------------------------------------------------------------------------
module u8d_out_reg
  import u8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  u8d_result_t result_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        ready_i,
  output u8d_result_t result_o
);

  logic        valid_q;
  u8d_result_t result_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

[rtl/utf8_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming UTF-8 to Unicode code point decoder.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the bytes of a string on the s_axis channel, one word per byte, with
//   s_axis_tlast set on the final byte of the string. Each completed sequence
//   yields one word on m_axis: the code point in tdata, tuser flags an error,
//   tlast marks the final result of the string. An error result always has
//   tlast set and a zero code point; the remaining bytes of that string are
//   dropped without results. Lead and continuation bytes that do not finish
//   a sequence yield no result unless they end the string; overlongs pass.
// Timing:
//   One byte per clock sustained while no result is stalled. A byte goes into
//   the input register, is decoded against the sequence state and lands in the
//   result register. The single decode step with its state update sets the
//   one-byte-per-cycle figure.
// Reset:
//   rst_ni clears both registers' valid flags and the sequence state; the
//   next byte is taken as the start of a new string.
// Stall:
//   While m_axis_tready is low, the result holds; the decoder keeps taking
//   bytes that produce no result, and holds the next result-producing byte
//   in the input register, which then backs s_axis_tready off.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
  import u8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_string
  // decoded code points
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_axis_tuser,   // error
  output logic        m_axis_tlast    // last
);

  // Input register
  logic                 in_vld_q;
  logic [ByteWidth-1:0] in_byte_q;
  logic                 in_eos_q;

  logic        step;
  logic        emit;
  logic        out_free;
  u8d_result_t dec_result;
  u8d_result_t out_result;

  // Advance the held byte unless its result has nowhere to go
  assign step          = in_vld_q && (!emit || out_free);
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  u8d_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .eos_i    (in_eos_q),
    .emit_o   (emit),
    .result_o (dec_result)
  );

  u8d_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && emit),
    .result_i (dec_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {3'b000, out_result.code_point};
  assign m_axis_tuser = out_result.error;
  assign m_axis_tlast = out_result.last;

endmodule

[rtl/u8d_checker.sv]
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the decoder output stream.
// ----------------------------------------------------------------------------
module u8d_checker
  import u8d_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // An error result closes the string
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error result without tlast");

  // An error result carries no code point
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
    else $error("error result with nonzero code point");

  // A good result is a scalar value
  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      !u8d_cp_bad(m_axis_tdata[CpWidth-1:0]) && m_axis_tdata[23:21] == 3'b000)
    else $error("code point out of range or surrogate");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_top u8d_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
